@@ rtl/sard_pkg.sv @@
// Shared types, constants and command/status structs of the slot allocator.
package sard_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int CFG_W          = 11;
    localparam int TIME_W         = 31;
    localparam int HW_W           = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 31;
    localparam int PASS_W         = 3;

    localparam int RESERVED_RST   = 64;
    localparam int LIMIT_RST      = 1022;
    localparam int START_RST      = 0;
    localparam int TOP_RST        = 64;

    localparam int FIRST_DELAY_MS = 1000;
    localparam int DELAY_STEP_MS  = 250;
    localparam int GRACE_MS       = 2000;
    localparam int PASS_COUNT     = 5;
    localparam int DELAY_W        = 11;

    // Slot word layout: in-use, pool mark, never-free mark, free time.
    localparam int WORD_W         = TIME_W + 3;
    localparam int BIT_IN_USE     = TIME_W + 2;
    localparam int BIT_POOL       = TIME_W + 1;
    localparam int BIT_NEVER      = TIME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_POOL  = 2'd2,
        MODE_NEVER = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NEVER     = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ARD,
        S_ACHK,
        S_APASS,
        S_GWR,
        S_MWR,
        S_FINIT,
        S_FRD,
        S_FCHK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_TOP,
        RD_REQ
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_TAKE,
        WR_GROW,
        WR_REQ
    } t_wr_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_TAKE,
        RES_GROW,
        RES_EXH,
        RES_NEVER,
        RES_RANGE
    } t_res_op;

    typedef struct packed {
        logic    latch;
        logic    clr_step;
        logic    scan_init;
        logic    scan_next;
        logic    pass_clr;
        logic    pass_next;
        logic    rd_req;
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        t_res_op res_op;
        logic    any_set;
        logic    any_clr;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic  clr_done;
        t_mode mode;
        logic  idx_oor;
        logic  scan_done;
        logic  qual;
        logic  slot_free;
        logic  never;
        logic  last_pass;
        logic  can_grow;
        logic  out_free;
    } t_sts;

    // Reuse delay of a scan pass.
    function automatic logic [DELAY_W-1:0] delay_of(input logic [PASS_W-1:0] pass);
        int d;
        d = FIRST_DELAY_MS - DELAY_STEP_MS * int'(pass);
        if (d < 0) begin
            d = 0;
        end
        return DELAY_W'(d);
    endfunction

endpackage

@@ rtl/sard_in_if.sv @@
// Request channel: valid/ready handshake carrying one request word.
interface sard_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [sard_pkg::IDX_W-1:0]    slot_index;
    logic                          flag_value;
    logic [sard_pkg::TIME_W-1:0]   now;

    modport source (output valid, mode, slot_index, flag_value, now, input ready);
    modport sink   (input valid, mode, slot_index, flag_value, now, output ready);
endinterface

@@ rtl/sard_out_if.sv @@
// Response channel: valid/ready handshake carrying one result word.
interface sard_out_if;
    logic                          valid;
    logic                          ready;
    logic [sard_pkg::IDX_W-1:0]    given_slot;
    logic [1:0]                    status;
    logic                          grew;
    logic                          any_free;
    logic [sard_pkg::HW_W-1:0]     high_water;

    modport source (output valid, given_slot, status, grew, any_free, high_water, input ready);
    modport sink   (input valid, given_slot, status, grew, any_free, high_water, output ready);
endinterface

@@ rtl/slot_allocator_with_reuse_delay_unit.sv @@
// Top level of the slot allocator with reuse delay.
// One request word is taken at a time and answered by one result word. After reset a
// clearing pass zeroes the slot table before the first request is accepted;
// configuration writes are taken meanwhile. Free and mark requests read the requested
// slot and update it (a never-free slot is not freed), then run the free-slot scan.
// Every request ends with a scan from the reserved count toward the high-water mark
// that stops at the first free slot. An allocate runs up to five passes over the same
// range, ending at the first qualifying slot; when a pass finds nothing and the mark may
// grow, the slot at the mark is taken. The slot RAM has a single read port, one slot
// word per read with registered read data. A finished result waits in an output register
// while the next request is accepted.
module slot_allocator_with_reuse_delay_unit #(
    parameter int SLOT_COUNT = sard_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sard_in_if.sink                         i_req,
    sard_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [sard_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sard_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    sard_pkg::t_cmd cmd;
    sard_pkg::t_sts sts;

    sard_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sard_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_req.mode),
        .i_slot_index (i_req.slot_index),
        .i_flag_value (i_req.flag_value),
        .i_now        (i_req.now),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_given_slot (o_rsp.given_slot),
        .o_status     (o_rsp.status),
        .o_grew       (o_rsp.grew),
        .o_any_free   (o_rsp.any_free),
        .o_high_water (o_rsp.high_water),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );
endmodule

@@ rtl/sard_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sard_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sard_dp.sv @@
// Datapath: configuration, high-water mark, scan counters, slot RAM and result registers.
module sard_dp #(
    parameter int SLOT_COUNT = sard_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sard_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sard_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_mode,
    input  logic [sard_pkg::IDX_W-1:0]        i_slot_index,
    input  logic                              i_flag_value,
    input  logic [sard_pkg::TIME_W-1:0]       i_now,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [sard_pkg::IDX_W-1:0]        o_given_slot,
    output logic [1:0]                        o_status,
    output logic                              o_grew,
    output logic                              o_any_free,
    output logic [sard_pkg::HW_W-1:0]         o_high_water,
    input  sard_pkg::t_cmd                    i_cmd,
    output sard_pkg::t_sts                    o_sts
);
    localparam int AW  = $clog2(SLOT_COUNT);
    localparam int CW  = $clog2(SLOT_COUNT + 1);
    localparam int TW  = (CW > sard_pkg::HW_W) ? CW : sard_pkg::HW_W;
    localparam logic [TW-1:0] SC = TW'(SLOT_COUNT);
    localparam int WW  = sard_pkg::WORD_W;
    localparam int TMW = sard_pkg::TIME_W;

    logic [sard_pkg::CFG_W-1:0]  r_reserved;
    logic [sard_pkg::CFG_W-1:0]  r_limit;
    logic [TMW-1:0]              r_start;
    logic [TW-1:0]               r_top;
    logic [TW-1:0]               r_scan;
    logic [AW-1:0]               r_clr;
    logic [sard_pkg::PASS_W-1:0] r_pass;
    sard_pkg::t_mode             r_mode;
    logic [sard_pkg::IDX_W-1:0]  r_idx;
    logic                        r_flag;
    logic [TMW-1:0]              r_now;
    logic [sard_pkg::IDX_W-1:0]  r_given;
    sard_pkg::t_status           r_status;
    logic                        r_grew;
    logic                        r_any;
    logic                        r_out_valid;
    logic [sard_pkg::IDX_W-1:0]  r_o_given;
    logic [1:0]                  r_o_status;
    logic                        r_o_grew;
    logic                        r_o_any;
    logic [sard_pkg::HW_W-1:0]   r_o_hw;

    logic [TW-1:0]  eff_res;
    logic [TW-1:0]  eff_res_new;
    logic [TW-1:0]  eff_top;
    logic [TW-1:0]  idx_ext;
    logic [WW-1:0]  rd_word;
    logic [TMW-1:0] ft;
    logic [sard_pkg::DELAY_W-1:0] delay;
    logic signed [TMW+1:0] age;
    logic           recent;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [WW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [WW-1:0]  req_word;
    logic [WW-1:0]  take_word;

    // Effective reserved count and top, clipped at the table size
    assign eff_res     = (TW'(r_reserved) > SC) ? SC : TW'(r_reserved);
    assign eff_res_new = (TW'(i_cfg_data[sard_pkg::CFG_W-1:0]) > SC) ? SC
                         : TW'(i_cfg_data[sard_pkg::CFG_W-1:0]);
    assign eff_top     = (r_top > SC) ? SC : r_top;
    assign idx_ext     = TW'(r_idx);

    // Qualify the slot word just read for the current pass
    assign ft     = rd_word[TMW-1:0];
    assign delay  = sard_pkg::delay_of(r_pass);
    assign age    = $signed({2'b00, r_now}) - $signed({2'b00, ft});
    assign recent = ({1'b0, ft} > ({1'b0, r_start} + (TMW+1)'(sard_pkg::GRACE_MS)))
                    && (age < $signed((TMW+2)'(delay)));

    assign o_sts.clr_done  = (r_clr == AW'(SLOT_COUNT - 1));
    assign o_sts.mode      = r_mode;
    assign o_sts.idx_oor   = (idx_ext >= SC);
    assign o_sts.scan_done = (r_scan >= eff_top);
    assign o_sts.qual      = !rd_word[sard_pkg::BIT_IN_USE] && !recent
                             && !(rd_word[sard_pkg::BIT_POOL] && (delay != '0));
    assign o_sts.slot_free = !rd_word[sard_pkg::BIT_IN_USE];
    assign o_sts.never     = rd_word[sard_pkg::BIT_NEVER];
    assign o_sts.last_pass = (r_pass == sard_pkg::PASS_W'(sard_pkg::PASS_COUNT - 1));
    assign o_sts.can_grow  = (r_top < TW'(r_limit)) && (r_top < SC);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Modified word for free and mark requests
    always_comb begin
        req_word = rd_word;
        unique case (r_mode)
            sard_pkg::MODE_FREE: begin
                req_word[sard_pkg::BIT_IN_USE] = 1'b0;
                req_word[TMW-1:0]              = r_now;
            end
            sard_pkg::MODE_POOL:  req_word[sard_pkg::BIT_POOL]  = r_flag;
            sard_pkg::MODE_NEVER: req_word[sard_pkg::BIT_NEVER] = r_flag;
            default: ;
        endcase
        take_word = rd_word;
        take_word[sard_pkg::BIT_IN_USE] = 1'b1;
    end

    // Select the RAM read address
    always_comb begin
        unique case (i_cmd.rd_sel)
            sard_pkg::RD_SCAN: ram_raddr = r_scan[AW-1:0];
            sard_pkg::RD_TOP:  ram_raddr = r_top[AW-1:0];
            sard_pkg::RD_REQ:  ram_raddr = idx_ext[AW-1:0];
            default:           ram_raddr = r_scan[AW-1:0];
        endcase
    end

    // Select the RAM write address and word
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = r_scan[AW-1:0];
        ram_wdata = take_word;
        unique case (i_cmd.wr_op)
            sard_pkg::WR_NONE:  ram_we = 1'b0;
            sard_pkg::WR_CLEAR: begin
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            sard_pkg::WR_TAKE:  ;
            sard_pkg::WR_GROW:  ram_waddr = r_top[AW-1:0];
            sard_pkg::WR_REQ: begin
                ram_waddr = idx_ext[AW-1:0];
                ram_wdata = req_word;
            end
            default: ram_we = 1'b0;
        endcase
    end

    sard_ram #(
        .WIDTH (WW),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_req),
        .i_raddr (ram_raddr),
        .o_rdata (rd_word)
    );

    // Configuration registers and high-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= sard_pkg::CFG_W'(sard_pkg::RESERVED_RST);
            r_limit    <= sard_pkg::CFG_W'(sard_pkg::LIMIT_RST);
            r_start    <= TMW'(sard_pkg::START_RST);
            r_top      <= TW'(sard_pkg::TOP_RST);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sard_pkg::CFG_RESERVED: begin
                        r_reserved <= i_cfg_data[sard_pkg::CFG_W-1:0];
                        if (r_top < eff_res_new) begin
                            r_top <= eff_res_new;
                        end
                    end
                    sard_pkg::CFG_LIMIT: r_limit <= i_cfg_data[sard_pkg::CFG_W-1:0];
                    sard_pkg::CFG_START: r_start <= i_cfg_data[TMW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.res_op == sard_pkg::RES_GROW) begin
                r_top <= r_top + TW'(1);
            end
        end
    end

    // Clear sweep, scan and pass counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_scan <= '0;
            r_pass <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.scan_init) begin
                r_scan <= eff_res;
            end else if (i_cmd.scan_next) begin
                r_scan <= r_scan + TW'(1);
            end
            if (i_cmd.pass_clr) begin
                r_pass <= '0;
            end else if (i_cmd.pass_next) begin
                r_pass <= r_pass + sard_pkg::PASS_W'(1);
            end
        end
    end

    // Hold the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= sard_pkg::t_mode'(i_mode);
            r_idx  <= i_slot_index;
            r_flag <= i_flag_value;
            r_now  <= i_now;
        end
    end

    // Build the result of the current request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_given  <= '0;
            r_status <= sard_pkg::ST_DONE;
            r_grew   <= 1'b0;
        end else begin
            unique case (i_cmd.res_op)
                sard_pkg::RES_NONE:  ;
                sard_pkg::RES_TAKE:  r_given <= r_scan[sard_pkg::IDX_W-1:0];
                sard_pkg::RES_GROW: begin
                    r_given <= r_top[sard_pkg::IDX_W-1:0];
                    r_grew  <= 1'b1;
                end
                sard_pkg::RES_EXH:   r_status <= sard_pkg::ST_EXHAUSTED;
                sard_pkg::RES_NEVER: r_status <= sard_pkg::ST_NEVER;
                sard_pkg::RES_RANGE: r_status <= sard_pkg::ST_RANGE;
                default: ;
            endcase
        end
        if (i_cmd.any_set) begin
            r_any <= 1'b1;
        end else if (i_cmd.any_clr) begin
            r_any <= 1'b0;
        end
    end

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_given  <= r_given;
            r_o_status <= r_status;
            r_o_grew   <= r_grew;
            r_o_any    <= r_any;
            r_o_hw     <= r_top[sard_pkg::HW_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_given_slot = r_o_given;
    assign o_status     = r_o_status;
    assign o_grew       = r_o_grew;
    assign o_any_free   = r_o_any;
    assign o_high_water = r_o_hw;

    // The high-water mark never drops
    a_top_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top >= $past(r_top))
        else $error("high-water mark decreased");

    // A slot is taken only when the word read for it qualifies
    a_take_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == sard_pkg::WR_TAKE) |-> o_sts.qual)
        else $error("slot taken without qualifying");

    // Growing only happens while below both limits
    a_grow_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_op == sard_pkg::RES_GROW) |-> o_sts.can_grow)
        else $error("grew past a limit");
endmodule

@@ rtl/sard_ctrl.sv @@
// Controller: sequences clear sweep, allocation passes, requests and the free-slot scan.
module sard_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sard_pkg::t_sts i_sts,
    output sard_pkg::t_cmd o_cmd
);
    sard_pkg::t_state r_state;
    sard_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sard_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.rd_sel     = sard_pkg::RD_SCAN;
        o_cmd.wr_op      = sard_pkg::WR_NONE;
        o_cmd.res_op     = sard_pkg::RES_NONE;
        unique case (r_state)
            sard_pkg::S_CLEAR: begin
                o_cmd.wr_op    = sard_pkg::WR_CLEAR;
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = sard_pkg::S_IDLE;
                end
            end
            sard_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = sard_pkg::S_DISPATCH;
                end
            end
            sard_pkg::S_DISPATCH: begin
                if (i_sts.mode == sard_pkg::MODE_ALLOC) begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.pass_clr  = 1'b1;
                    n_state         = sard_pkg::S_ARD;
                end else if (i_sts.idx_oor) begin
                    o_cmd.res_op = sard_pkg::RES_RANGE;
                    n_state      = sard_pkg::S_FINIT;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    o_cmd.rd_sel = sard_pkg::RD_REQ;
                    n_state      = sard_pkg::S_MWR;
                end
            end
            sard_pkg::S_ARD: begin
                if (i_sts.scan_done) begin
                    n_state = sard_pkg::S_APASS;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state      = sard_pkg::S_ACHK;
                end
            end
            sard_pkg::S_ACHK: begin
                if (i_sts.qual) begin
                    o_cmd.wr_op  = sard_pkg::WR_TAKE;
                    o_cmd.res_op = sard_pkg::RES_TAKE;
                    n_state      = sard_pkg::S_FINIT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = sard_pkg::S_ARD;
                end
            end
            sard_pkg::S_APASS: begin
                priority if (i_sts.can_grow) begin
                    o_cmd.rd_req = 1'b1;
                    o_cmd.rd_sel = sard_pkg::RD_TOP;
                    n_state      = sard_pkg::S_GWR;
                end else if (i_sts.last_pass) begin
                    o_cmd.res_op = sard_pkg::RES_EXH;
                    n_state      = sard_pkg::S_FINIT;
                end else begin
                    o_cmd.pass_next = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = sard_pkg::S_ARD;
                end
            end
            sard_pkg::S_GWR: begin
                o_cmd.wr_op  = sard_pkg::WR_GROW;
                o_cmd.res_op = sard_pkg::RES_GROW;
                n_state      = sard_pkg::S_FINIT;
            end
            sard_pkg::S_MWR: begin
                if (i_sts.mode == sard_pkg::MODE_FREE && i_sts.never) begin
                    o_cmd.res_op = sard_pkg::RES_NEVER;
                end else begin
                    o_cmd.wr_op = sard_pkg::WR_REQ;
                end
                n_state = sard_pkg::S_FINIT;
            end
            sard_pkg::S_FINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = sard_pkg::S_FRD;
            end
            sard_pkg::S_FRD: begin
                if (i_sts.scan_done) begin
                    o_cmd.any_clr = 1'b1;
                    n_state       = sard_pkg::S_OUT;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state      = sard_pkg::S_FCHK;
                end
            end
            sard_pkg::S_FCHK: begin
                if (i_sts.slot_free) begin
                    o_cmd.any_set = 1'b1;
                    n_state       = sard_pkg::S_OUT;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = sard_pkg::S_FRD;
                end
            end
            sard_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sard_pkg::S_IDLE;
                end
            end
            default: n_state = sard_pkg::S_IDLE;
        endcase
    end

    // A result is loaded only into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a waiting word");

    // Only one request is in flight: no accept while a result is being built
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> !o_in_ready)
        else $error("second request accepted in flight");

    // The RAM is never written during the free-slot scan
    a_scan_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sard_pkg::S_FRD || r_state == sard_pkg::S_FCHK)
        |-> (o_cmd.wr_op == sard_pkg::WR_NONE))
        else $error("slot table written during free scan");
endmodule
